>>> sv/tqla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_pkg
// Types, codes and constants of the tabular Q-learning agent.
// ----------------------------------------------------------------------------
package tqla_pkg;

  localparam int ROWS_DEF    = 4;
  localparam int COLS_DEF    = 4;
  localparam int ACTIONS_DEF = 8;

  localparam int ACT_W    = 5;
  localparam int DIV_BITS = 48;
  localparam int CNT_W    = 6;

  localparam logic [34:0] RECIP10 = 35'h0CCCCCCCD;

  typedef enum logic [1:0] {
    OP_CHOOSE = 2'd0,
    OP_UPDATE = 2'd1,
    OP_FILL   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_LEARN   = 3'd0,
    REG_DISC    = 3'd1,
    REG_EXPLORE = 3'd2,
    REG_INIT    = 3'd3,
    REG_PENALTY = 3'd4,
    REG_BONUS   = 3'd5,
    REG_ACTIONS = 3'd6,
    REG_TOL     = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CH_RD,
    ST_CH_CMP,
    ST_DIV,
    ST_SUM,
    ST_RW_MUL,
    ST_RW_SAT,
    ST_NX_RD,
    ST_NX_CMP,
    ST_Q_RD,
    ST_Q_GET,
    ST_G_MUL,
    ST_TD,
    ST_A_MUL,
    ST_WR
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    if (x > 38'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -38'sh0_8000_0000) return -32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

>>> sv/tabular_q_learning_agent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_agent
// Q table with epsilon-greedy choose, Q-learning update and table fill.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// shows on the result ports for one cycle with done_o and cannot be stalled.
// Fill and unused operation codes finish without leaving idle. Choose scans
// the n entries of the state (n = effective action count) through one table
// read port, a read state and a compare state per entry. Update runs a
// 48-step radix-2 divider for the fitness ratio, then the next-state scan and
// three products on one shared 36x18 multiplier. Fill is instant: per-entry
// valid bits fall back to the last fill value, so there is no clearing pass.
module tabular_q_learning_agent
  import tqla_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLS    = COLS_DEF,
  parameter int ACTIONS = ACTIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [1:0]         state_row_i,
  input  logic [1:0]         state_col_i,
  input  logic [1:0]         next_row_i,
  input  logic [1:0]         next_col_i,
  input  logic [3:0]         taken_action_i,
  input  logic [31:0]        fit_before_i,
  input  logic [31:0]        fit_after_i,
  input  logic [16:0]        reward_scale_i,
  input  logic [15:0]        explore_draw_i,
  input  logic [3:0]         random_action_i,
  output logic               done_o,
  output logic [3:0]         chosen_action_o,
  output logic signed [31:0] new_value_o,
  output logic               was_random_o
);

  localparam int DEPTH  = ROWS * COLS * ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] base_of(input logic [1:0] r, input logic [1:0] c);
    int ri;
    int ci;
    int s;
    ri = (int'(r) >= ROWS) ? ROWS - 1 : int'(r);
    ci = (int'(c) >= COLS) ? COLS - 1 : int'(c);
    s  = (ri * COLS + ci) * ACTIONS;
    return s[ADDR_W-1:0];
  endfunction

  // config registers
  logic [16:0]        learn_q, disc_q, explore_q;
  logic [30:0]        init_q;
  logic signed [31:0] penalty_q, bonus_q;
  logic [3:0]         actcnt_q;
  logic [15:0]        tol_q;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q   <= 17'd6554;
      disc_q    <= 17'd58982;
      explore_q <= 17'd6554;
      init_q    <= 31'd65536;
      penalty_q <= '0;
      bonus_q   <= '0;
      actcnt_q  <= 4'd6;
      tol_q     <= 16'd1;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[4:2]))
        REG_LEARN:   learn_q   <= pwdata[16:0];
        REG_DISC:    disc_q    <= pwdata[16:0];
        REG_EXPLORE: explore_q <= pwdata[16:0];
        REG_INIT:    init_q    <= pwdata[30:0];
        REG_PENALTY: penalty_q <= pwdata;
        REG_BONUS:   bonus_q   <= pwdata;
        REG_ACTIONS: actcnt_q  <= pwdata[3:0];
        REG_TOL:     tol_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_LEARN:   prdata = {15'd0, learn_q};
      REG_DISC:    prdata = {15'd0, disc_q};
      REG_EXPLORE: prdata = {15'd0, explore_q};
      REG_INIT:    prdata = {1'b0, init_q};
      REG_PENALTY: prdata = penalty_q;
      REG_BONUS:   prdata = bonus_q;
      REG_ACTIONS: prdata = {28'd0, actcnt_q};
      REG_TOL:     prdata = {16'd0, tol_q};
      default:     prdata = '0;
    endcase
  end

  // effective action count and clamping
  logic [ACT_W-1:0] n_eff;
  always_comb begin
    if (actcnt_q == 4'd0) n_eff = ACT_W'(1);
    else if (ACT_W'(actcnt_q) > ACT_W'(ACTIONS)) n_eff = ACT_W'(ACTIONS);
    else n_eff = ACT_W'(actcnt_q);
  end

  function automatic logic [ACT_W-1:0] clamp_act(input logic [3:0] a, input logic [ACT_W-1:0] n);
    if (a == 4'd0) return ACT_W'(1);
    if (ACT_W'(a) > n) return n;
    return ACT_W'(a);
  endfunction

  // table: memory plus valid bits over the last fill value
  logic signed [31:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic signed [31:0] fillv_q;
  logic signed [31:0] rd_data_q;
  logic               rd_vld_q;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [31:0] rd_val;
  logic               wr_en;
  logic               fill_en;
  logic signed [31:0] nv;

  assign rd_val = rd_vld_q ? rd_data_q : fillv_q;

  state_e state_q, state_d;
  logic   accept;
  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  // latched request
  logic [ADDR_W-1:0]  b_q, nb_q;
  logic [ACT_W-1:0]   act_q, rnd_q, idx_q;
  logic               expl_q;
  logic [31:0]        before_q;
  logic               neg_q, ge_q, near_q;
  logic [16:0]        scale_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [32:0]        rem_q;
  logic [DIV_BITS-1:0] quo_q;

  // choose scan
  logic signed [31:0] q1_q, bv_q;
  logic [ACT_W-1:0]   best_q;
  logic               close_q;

  // update datapath
  logic signed [31:0] sum_q, reward_q, m_q, qv_q;
  logic signed [35:0] td_q;
  logic signed [53:0] prod_q;
  logic signed [35:0] mul_a;
  logic [16:0]        mul_b;
  logic [27:0]        floor_q;
  logic [62:0]        div10;

  assign div10 = {32'd0, init_q} * {28'd0, RECIP10};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_CHOOSE: state_d = ST_CH_RD;
            OP_UPDATE: state_d = ST_DIV;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CH_RD:  state_d = ST_CH_CMP;
      ST_CH_CMP: state_d = (idx_q == n_eff) ? ST_IDLE : ST_CH_RD;
      ST_DIV:    state_d = (cnt_q == CNT_W'(DIV_BITS - 1)) ? ST_SUM : ST_DIV;
      ST_SUM:    state_d = ST_RW_MUL;
      ST_RW_MUL: state_d = ST_RW_SAT;
      ST_RW_SAT: state_d = ST_NX_RD;
      ST_NX_RD:  state_d = ST_NX_CMP;
      ST_NX_CMP: state_d = (idx_q == n_eff) ? ST_Q_RD : ST_NX_RD;
      ST_Q_RD:   state_d = ST_Q_GET;
      ST_Q_GET:  state_d = ST_G_MUL;
      ST_G_MUL:  state_d = ST_TD;
      ST_TD:     state_d = ST_A_MUL;
      ST_A_MUL:  state_d = ST_WR;
      ST_WR:     state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = b_q;
    mul_a   = '0;
    mul_b   = '0;
    wr_en   = 1'b0;
    fill_en = 1'b0;
    case (state_q)
      ST_IDLE: fill_en = accept && (op_e'(operation_i) == OP_FILL);
      ST_CH_RD: begin
        rd_en   = 1'b1;
        rd_addr = b_q + ADDR_W'(idx_q - ACT_W'(1));
      end
      ST_NX_RD: begin
        rd_en   = 1'b1;
        rd_addr = nb_q + ADDR_W'(idx_q - ACT_W'(1));
      end
      ST_Q_RD: begin
        rd_en   = 1'b1;
        rd_addr = b_q + ADDR_W'(act_q - ACT_W'(1));
      end
      ST_RW_MUL: begin
        mul_a = 36'(sum_q);
        mul_b = scale_q;
      end
      ST_G_MUL: begin
        mul_a = 36'(m_q);
        mul_b = disc_q;
      end
      ST_A_MUL: begin
        mul_a = td_q;
        mul_b = learn_q;
      end
      ST_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[b_q + ADDR_W'(act_q - ACT_W'(1))] <= nv;
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      fillv_q <= '0;
    end else if (fill_en) begin
      vld_q   <= '0;
      fillv_q <= {1'b0, init_q};
    end else if (wr_en) begin
      vld_q[b_q + ADDR_W'(act_q - ACT_W'(1))] <= 1'b1;
    end
  end

  // combinational datapath pieces
  logic signed [32:0] diff, vd;
  logic [32:0]        mag, vabs, rem_sh;
  logic               rem_ge;
  logic signed [32:0] ratio;
  logic signed [31:0] bias;
  logic signed [37:0] gterm, nv_wide;

  assign diff   = $signed({1'b0, fit_before_i | {31'd0, fit_before_i == 32'd0}})
                - $signed({1'b0, fit_after_i});
  assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
  assign rem_sh = {rem_q[31:0], quo_q[DIV_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, before_q};
  assign vd     = $signed({rd_val[31], rd_val}) - $signed({q1_q[31], q1_q});
  assign vabs   = vd[32] ? 33'(-vd) : 33'(vd);
  assign bias   = (ge_q || near_q) ? penalty_q : bonus_q;
  assign gterm  = 38'(prod_q >>> 16);
  assign nv_wide = 38'(qv_q) + gterm;

  always_comb begin
    if (neg_q) begin
      if (quo_q > DIV_BITS'(33'h0_8000_0000)) ratio = -33'sh0_8000_0000;
      else ratio = 33'(-$signed({1'b0, quo_q[32:0]}));
    end else begin
      if (quo_q > DIV_BITS'(33'h0_7FFF_FFFF)) ratio = 33'sh0_7FFF_FFFF;
      else ratio = $signed(quo_q[32:0]);
    end
  end

  always_comb begin
    logic signed [31:0] s;
    s  = sat32(gterm);
    nv = s;
    if (sat32(nv_wide) < $signed({4'd0, floor_q})) nv = $signed({4'd0, floor_q});
    else nv = sat32(nv_wide);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    floor_q <= div10[62:35];
    prod_q  <= mul_a * $signed({1'b0, mul_b});
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          b_q      <= base_of(state_row_i, state_col_i);
          nb_q     <= base_of(next_row_i, next_col_i);
          act_q    <= clamp_act(taken_action_i, n_eff);
          rnd_q    <= clamp_act(random_action_i, n_eff);
          expl_q   <= {1'b0, explore_draw_i} < explore_q;
          idx_q    <= ACT_W'(1);
          before_q <= fit_before_i | {31'd0, fit_before_i == 32'd0};
          neg_q    <= diff[32];
          ge_q     <= diff[32] || (diff == 33'sd0);
          near_q   <= mag <= {25'd0, tol_q[15:8]};
          scale_q  <= reward_scale_i;
          cnt_q    <= '0;
          rem_q    <= '0;
          quo_q    <= {mag[31:0], 16'd0};
        end
      end
      ST_CH_CMP: begin
        if (idx_q == ACT_W'(1)) begin
          q1_q    <= rd_val;
          bv_q    <= rd_val;
          best_q  <= ACT_W'(1);
          close_q <= 1'b1;
        end else begin
          if (vabs > {17'd0, tol_q}) close_q <= 1'b0;
          if (rd_val > bv_q) begin
            bv_q   <= rd_val;
            best_q <= idx_q;
          end
        end
        idx_q <= idx_q + ACT_W'(1);
      end
      ST_DIV: begin
        rem_q <= rem_ge ? rem_sh - {1'b0, before_q} : rem_sh;
        quo_q <= {quo_q[DIV_BITS-2:0], rem_ge};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_SUM:    sum_q <= sat32(38'(ratio) + 38'(bias));
      ST_RW_SAT: begin
        reward_q <= sat32(gterm);
        idx_q    <= ACT_W'(1);
      end
      ST_NX_CMP: begin
        if (idx_q == ACT_W'(1) || rd_val > m_q) m_q <= rd_val;
        idx_q <= idx_q + ACT_W'(1);
      end
      ST_Q_GET: qv_q <= rd_val;
      ST_TD:    td_q <= 36'(38'(reward_q) + gterm - 38'(qv_q));
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o          <= 1'b0;
      chosen_action_o <= '0;
      new_value_o     <= '0;
      was_random_o    <= 1'b0;
    end else begin
      done_o          <= 1'b0;
      chosen_action_o <= '0;
      new_value_o     <= '0;
      was_random_o    <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && !(op_e'(operation_i) inside {OP_CHOOSE, OP_UPDATE}))
            done_o <= 1'b1;
        end
        ST_CH_CMP: begin
          if (idx_q == n_eff) begin
            logic cl;
            logic [ACT_W-1:0] bst;
            done_o <= 1'b1;
            cl  = (idx_q == ACT_W'(1)) ? 1'b1 : (close_q && !(vabs > {17'd0, tol_q}));
            bst = (idx_q != ACT_W'(1) && rd_val > bv_q) ? idx_q : best_q;
            if (idx_q == ACT_W'(1)) bst = ACT_W'(1);
            if (expl_q || cl) begin
              chosen_action_o <= rnd_q[3:0];
              was_random_o    <= 1'b1;
            end else begin
              chosen_action_o <= bst[3:0];
            end
          end
        end
        ST_WR: begin
          done_o      <= 1'b1;
          new_value_o <= nv;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/tqla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_checker
// Port-level checks of the Q-learning agent, bound to the top level.
// ----------------------------------------------------------------------------
module tqla_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [3:0]         chosen_action_o,
  input logic signed [31:0] new_value_o,
  input logic               was_random_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("request dropped");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (chosen_action_o == 4'd0 || new_value_o == 32'sd0))
    else $error("choose and update result mixed");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (chosen_action_o == 4'd0 && new_value_o == 32'sd0 && !was_random_o))
    else $error("result ports not quiet");

  a_random_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    was_random_o |-> (done_o && chosen_action_o != 4'd0))
    else $error("random flag without action");

endmodule

bind tabular_q_learning_agent tqla_checker u_tqla_checker (.*);
